// File: hdl/bpc_pkg.sv
// Package for the barometric pressure compensation block.
// Holds item types and fixed compensation constants; no dependencies.
package bpc_pkg;

    localparam int unsigned NUM_CFG  = 6;
    localparam int unsigned CFG_IDXW = 3;
    localparam int unsigned CFG_W    = 32;

    // Register indexes
    localparam logic [CFG_IDXW-1:0] CFG_AC1_AC2 = 3'd0;
    localparam logic [CFG_IDXW-1:0] CFG_AC3_AC4 = 3'd1;
    localparam logic [CFG_IDXW-1:0] CFG_AC5_AC6 = 3'd2;
    localparam logic [CFG_IDXW-1:0] CFG_B1_B2   = 3'd3;
    localparam logic [CFG_IDXW-1:0] CFG_MC_MD   = 3'd4;
    localparam logic [CFG_IDXW-1:0] CFG_OSS     = 3'd5;

    // Compensation constants
    localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
    localparam logic signed [31:0] P_QUAD_K   = 32'sd3038;
    localparam logic signed [31:0] P_LIN_K    = -32'sd7357;
    localparam logic signed [31:0] P_OFFSET   = 32'sd3791;
    localparam logic        [31:0] B7_SCALE   = 32'd50000;
    localparam logic signed [31:0] B4_BIAS    = 32'sd32768;
    localparam logic        [31:0] B7_SPLIT   = 32'h8000_0000;

    localparam logic signed [15:0] T_MAX = 16'sh7FFF;
    localparam logic signed [15:0] T_MIN = -16'sh8000;
    localparam logic [17:0]        P_MAX = 18'h3FFFF;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic        [17:0] pressure_pa;
        logic               divide_error;
    } t_out_item;

endpackage

// File: hdl/bpc_in_if.sv
// Input channel of the pressure compensation block: valid, ready, one reading pair.
// Depends on bpc_pkg for the item type.
interface bpc_in_if;
    logic                valid;
    logic                ready;
    bpc_pkg::t_in_item   data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: hdl/bpc_out_if.sv
// Output channel of the pressure compensation block: valid, ready, one result.
// Depends on bpc_pkg for the item type.
interface bpc_out_if;
    logic                valid;
    logic                ready;
    bpc_pkg::t_out_item  data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: hdl/barometric_pressure_compensation.sv
// Top level of the barometric pressure compensation pipeline.
// Depends on bpc_pkg, bpc_in_if, bpc_out_if and bpc_div.
//
//  channel   direction  payload                                         handshake
//  i_in      in         raw_temperature[15:0], raw_pressure[18:0]      valid/ready
//  o_out     out        temperature_tenths[15:0] s, pressure_pa[17:0],  valid/ready
//                       divide_error
//  i_cfg_*   in         index[2:0], data[31:0]                          write enable
//
// One item enters per cycle while the pipeline is not stalled; each item passes
// through the two 32-stage dividers (temperature X2, pressure quotient) and
// ten arithmetic stages around them.
// Reset (synchronous, active low) clears all valid bits and the configuration registers.
// The whole pipeline advances as one when the output register is empty or taken;
// otherwise every stage holds, so nothing is lost or repeated.
module barometric_pressure_compensation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bpc_in_if.sink                        i_in,
    bpc_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [bpc_pkg::CFG_IDXW-1:0]  i_cfg_idx,
    input  logic [bpc_pkg::CFG_W-1:0]     i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] r_cal [0:4];
    logic [1:0]  r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_cal[i] <= '0;
            end
            r_oss <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bpc_pkg::CFG_AC1_AC2: r_cal[0] <= i_cfg_data;
                bpc_pkg::CFG_AC3_AC4: r_cal[1] <= i_cfg_data;
                bpc_pkg::CFG_AC5_AC6: r_cal[2] <= i_cfg_data;
                bpc_pkg::CFG_B1_B2:   r_cal[3] <= i_cfg_data;
                bpc_pkg::CFG_MC_MD:   r_cal[4] <= i_cfg_data;
                bpc_pkg::CFG_OSS:     r_oss    <= i_cfg_data[1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // Coefficients widened to 32 bits (signed or zero extended)
    logic signed [31:0] c_ac1, c_ac2, c_ac3, c_ac4, c_ac5, c_ac6;
    logic signed [31:0] c_b1, c_b2, c_mc, c_md;

    assign c_ac1 = 32'($signed(r_cal[0][31:16]));
    assign c_ac2 = 32'($signed(r_cal[0][15:0]));
    assign c_ac3 = 32'($signed(r_cal[1][31:16]));
    assign c_ac4 = $signed({16'b0, r_cal[1][15:0]});
    assign c_ac5 = $signed({16'b0, r_cal[2][31:16]});
    assign c_ac6 = $signed({16'b0, r_cal[2][15:0]});
    assign c_b1  = 32'($signed(r_cal[3][31:16]));
    assign c_b2  = 32'($signed(r_cal[3][15:0]));
    assign c_mc  = 32'($signed(r_cal[4][31:16]));
    assign c_md  = 32'($signed(r_cal[4][15:0]));

    // ------------------------------------------------------------------
    // Global advance: move every stage when the output slot frees up
    // ------------------------------------------------------------------
    logic en;
    logic r_out_vld;

    assign en         = !r_out_vld || o_out.ready;
    assign i_in.ready = en;

    // ------------------------------------------------------------------
    // Stage 1: X1 of the temperature
    // ------------------------------------------------------------------
    logic               r1_vld;
    logic signed [31:0] r1_x1;
    logic [18:0]        r1_up;
    logic signed [31:0] s1_d, s1_prod;

    assign s1_d    = $signed({16'b0, i_in.data.raw_temperature}) - c_ac6;
    assign s1_prod = s1_d * c_ac5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x1 <= s1_prod >>> 15;
            r1_up <= i_in.data.raw_pressure;
        end
    end

    // ------------------------------------------------------------------
    // Divider 1: X2 = (mc * 2048) / (X1 + md), signed, truncating
    // ------------------------------------------------------------------
    localparam int unsigned D1_SW = 32 + 19 + 2;

    logic signed [31:0] d1_den, d1_numv;
    logic [31:0]        d1_num_mag, d1_den_mag;
    logic               d1_vld_o;
    logic [31:0]        d1_quo;
    logic [D1_SW-1:0]   d1_side_i, d1_side_o;

    assign d1_den     = r1_x1 + c_md;
    assign d1_numv    = c_mc <<< 11;
    assign d1_num_mag = d1_numv[31] ? 32'(-d1_numv) : d1_numv;
    assign d1_den_mag = d1_den[31]  ? 32'(-d1_den)  : d1_den;
    // side: quotient sign, zero divisor, raw pressure, X1
    assign d1_side_i  = {d1_numv[31] ^ d1_den[31], (d1_den == 32'sd0), r1_up, r1_x1};

    bpc_div #(.SW(D1_SW)) u_div_t (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r1_vld),
        .i_num  (d1_num_mag),
        .i_den  (d1_den_mag),
        .i_side (d1_side_i),
        .o_vld  (d1_vld_o),
        .o_quo  (d1_quo),
        .o_side (d1_side_o)
    );

    // ------------------------------------------------------------------
    // Stage 3: B5, temperature, B6
    // ------------------------------------------------------------------
    logic               r3_vld, r3_err;
    logic signed [15:0] r3_t;
    logic signed [31:0] r3_b6;
    logic [18:0]        r3_up;
    logic signed [31:0] s3_x1, s3_x2, s3_b5, s3_t;
    logic signed [15:0] s3_tsat;

    assign s3_x1 = $signed(d1_side_o[31:0]);
    assign s3_x2 = d1_side_o[D1_SW-1] ? 32'(-$signed(d1_quo)) : $signed(d1_quo);
    assign s3_b5 = s3_x1 + s3_x2;
    assign s3_t  = (s3_b5 + 32'sd8) >>> 4;

    always_comb begin
        priority if (!s3_t[31] && (s3_t[30:15] != '0)) begin
            s3_tsat = bpc_pkg::T_MAX;
        end else if (s3_t[31] && (s3_t[30:15] != '1)) begin
            s3_tsat = bpc_pkg::T_MIN;
        end else begin
            s3_tsat = s3_t[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= d1_vld_o;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_err <= d1_side_o[D1_SW-2];
            r3_t   <= s3_tsat;
            r3_b6  <= s3_b5 - bpc_pkg::B6_OFFSET;
            r3_up  <= d1_side_o[50:32];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: B6 squared, ac2 and ac3 terms
    // ------------------------------------------------------------------
    logic               r4_vld, r4_err;
    logic signed [15:0] r4_t;
    logic signed [31:0] r4_sq, r4_x2a, r4_x1c;
    logic [18:0]        r4_up;
    logic signed [31:0] s4_sq, s4_a2, s4_a3;

    assign s4_sq = r3_b6 * r3_b6;
    assign s4_a2 = c_ac2 * r3_b6;
    assign s4_a3 = c_ac3 * r3_b6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_err <= r3_err;
            r4_t   <= r3_t;
            r4_up  <= r3_up;
            r4_sq  <= s4_sq >>> 12;
            r4_x2a <= s4_a2 >>> 11;
            r4_x1c <= s4_a3 >>> 13;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: b2 and b1 terms
    // ------------------------------------------------------------------
    logic               r5_vld, r5_err;
    logic signed [15:0] r5_t;
    logic signed [31:0] r5_x1b, r5_x2a, r5_x1c, r5_x2c;
    logic [18:0]        r5_up;
    logic signed [31:0] s5_pb2, s5_pb1;

    assign s5_pb2 = c_b2 * r4_sq;
    assign s5_pb1 = c_b1 * r4_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_err <= r4_err;
            r5_t   <= r4_t;
            r5_up  <= r4_up;
            r5_x1b <= s5_pb2 >>> 11;
            r5_x2a <= r4_x2a;
            r5_x1c <= r4_x1c;
            r5_x2c <= s5_pb1 >>> 16;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: B3 and the X3 feeding B4
    // ------------------------------------------------------------------
    logic               r6_vld, r6_err;
    logic signed [15:0] r6_t;
    logic signed [31:0] r6_b3, r6_x3;
    logic [18:0]        r6_up;
    logic signed [31:0] s6_x3, s6_v, s6_b3n;

    assign s6_x3  = r5_x1b + r5_x2a;
    assign s6_v   = (((c_ac1 <<< 2) + s6_x3) <<< r_oss) + 32'sd2;
    // divide by four rounding toward zero
    assign s6_b3n = s6_v[31] ? (s6_v + 32'sd3) : s6_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_err <= r5_err;
            r6_t   <= r5_t;
            r6_up  <= r5_up;
            r6_b3  <= s6_b3n >>> 2;
            r6_x3  <= (r5_x1c + r5_x2c + 32'sd2) >>> 2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: B4 and UP - B3
    // ------------------------------------------------------------------
    logic               r7_vld, r7_err;
    logic signed [15:0] r7_t;
    logic [31:0]        r7_b4, r7_diff;
    logic [31:0]        s7_prod;

    assign s7_prod = $unsigned(c_ac4) * $unsigned(r6_x3 + bpc_pkg::B4_BIAS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_err  <= r6_err;
            r7_t    <= r6_t;
            r7_b4   <= s7_prod >> 15;
            r7_diff <= {13'b0, r6_up} - $unsigned(r6_b3);
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: B7
    // ------------------------------------------------------------------
    logic               r8_vld, r8_err;
    logic signed [15:0] r8_t;
    logic [31:0]        r8_b4, r8_b7;
    logic [31:0]        s8_scale;

    assign s8_scale = bpc_pkg::B7_SCALE >> r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (en) begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_err <= r7_err || (r7_b4 == '0);
            r8_t   <= r7_t;
            r8_b4  <= r7_b4;
            r8_b7  <= r7_diff * s8_scale;
        end
    end

    // ------------------------------------------------------------------
    // Divider 2: pressure quotient with the B7 split
    // ------------------------------------------------------------------
    localparam int unsigned D2_SW = 16 + 2;

    logic             d2_split;
    logic [31:0]      d2_num;
    logic             d2_vld_o;
    logic [31:0]      d2_quo;
    logic [D2_SW-1:0] d2_side_o;

    // below the split point double first, above it double the quotient
    assign d2_split = (r8_b7 >= bpc_pkg::B7_SPLIT);
    assign d2_num   = d2_split ? r8_b7 : {r8_b7[30:0], 1'b0};

    bpc_div #(.SW(D2_SW)) u_div_p (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r8_vld),
        .i_num  (d2_num),
        .i_den  (r8_b4),
        .i_side ({d2_split, r8_err, r8_t}),
        .o_vld  (d2_vld_o),
        .o_quo  (d2_quo),
        .o_side (d2_side_o)
    );

    // ------------------------------------------------------------------
    // Stage 9: p, its square term and linear term
    // ------------------------------------------------------------------
    logic               r9_vld, r9_err;
    logic signed [15:0] r9_t;
    logic signed [31:0] r9_p, r9_x1sq, r9_x2;
    logic signed [31:0] s9_p, s9_x1, s9_lin;

    assign s9_p   = d2_side_o[D2_SW-1] ? $signed({d2_quo[30:0], 1'b0}) : $signed(d2_quo);
    assign s9_x1  = s9_p >>> 8;
    assign s9_lin = bpc_pkg::P_LIN_K * s9_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else if (en) begin
            r9_vld <= d2_vld_o;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_err   <= d2_side_o[D2_SW-2];
            r9_t     <= $signed(d2_side_o[15:0]);
            r9_p     <= s9_p;
            r9_x1sq  <= s9_x1 * s9_x1;
            r9_x2    <= s9_lin >>> 16;
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: scale the square term
    // ------------------------------------------------------------------
    logic               r10_vld, r10_err;
    logic signed [15:0] r10_t;
    logic signed [31:0] r10_p, r10_x1, r10_x2;
    logic signed [31:0] s10_q;

    assign s10_q = r9_x1sq * bpc_pkg::P_QUAD_K;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else if (en) begin
            r10_vld <= r9_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_err <= r9_err;
            r10_t   <= r9_t;
            r10_p   <= r9_p;
            r10_x1  <= s10_q >>> 16;
            r10_x2  <= r9_x2;
        end
    end

    // ------------------------------------------------------------------
    // Output register: final pressure, saturation, divide error
    // ------------------------------------------------------------------
    logic signed [31:0]  s11_p;
    logic [17:0]         s11_psat;
    bpc_pkg::t_out_item  r_out;

    assign s11_p = r10_p + ((r10_x1 + r10_x2 + bpc_pkg::P_OFFSET) >>> 4);

    always_comb begin
        priority if (s11_p[31]) begin
            s11_psat = '0;
        end else if (s11_p[30:18] != '0) begin
            s11_psat = bpc_pkg::P_MAX;
        end else begin
            s11_psat = s11_p[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r10_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.divide_error       <= r10_err;
            r_out.temperature_tenths <= r10_err ? 16'sd0 : r10_t;
            r_out.pressure_pa        <= r10_err ? 18'd0 : s11_psat;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.divide_error) |->
            (o_out.data.temperature_tenths == 16'sd0 && o_out.data.pressure_pa == 18'd0))
        else $error("divide error with nonzero results");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |=> o_out.valid)
        else $error("pending result dropped during stall");

    a_stall_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r10_vld) && $stable(d2_vld_o) && $stable(d1_vld_o)))
        else $error("pipeline moved while stalled");

endmodule

// File: hdl/bpc_div.sv
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// Carries a side payload of SW bits alongside each item; no package use.
module bpc_div #(
    parameter int unsigned SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [31:0]   i_num,
    input  logic [31:0]   i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [31:0]   o_quo,
    output logic [SW-1:0] o_side
);

    localparam int unsigned NST = 32;

    logic          r_vld  [1:NST];
    logic [31:0]   r_rem  [1:NST];
    logic [31:0]   r_num  [1:NST];
    logic [31:0]   r_den  [1:NST];
    logic [31:0]   r_quo  [1:NST];
    logic [SW-1:0] r_side [1:NST];

    genvar k;
    generate
        for (k = 0; k < NST; k++) begin : g_st
            logic          w_vld;
            logic [31:0]   w_rem, w_num, w_den, w_quo;
            logic [SW-1:0] w_side;
            logic [32:0]   w_trial;
            logic          w_ge;

            if (k == 0) begin : g_first
                assign w_vld  = i_vld;
                assign w_rem  = '0;
                assign w_num  = i_num;
                assign w_den  = i_den;
                assign w_quo  = '0;
                assign w_side = i_side;
            end else begin : g_next
                assign w_vld  = r_vld[k];
                assign w_rem  = r_rem[k];
                assign w_num  = r_num[k];
                assign w_den  = r_den[k];
                assign w_quo  = r_quo[k];
                assign w_side = r_side[k];
            end

            // Shift in the next dividend bit, subtract if it fits
            assign w_trial = {w_rem, w_num[31]};
            assign w_ge    = (w_trial >= {1'b0, w_den});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k+1] <= w_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1]  <= w_ge ? 32'(w_trial - {1'b0, w_den}) : w_trial[31:0];
                    r_num[k+1]  <= {w_num[30:0], 1'b0};
                    r_den[k+1]  <= w_den;
                    r_quo[k+1]  <= {w_quo[30:0], w_ge};
                    r_side[k+1] <= w_side;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[NST];
    assign o_quo  = r_quo[NST];
    assign o_side = r_side[NST];

endmodule

// File: bench/barometric_pressure_compensation_test.sv
`timescale 1ns / 1ps
// Testbench for barometric_pressure_compensation: directed and random reading pairs,
// checked against a local integer model of the compensation.
// Depends on bpc_pkg, bpc_in_if, bpc_out_if and the block itself.
module barometric_pressure_compensation_test;

    localparam int unsigned PIPE_LATENCY  = 74;
    localparam int unsigned SETTLE_CYCLES = PIPE_LATENCY + 20;
    localparam int unsigned STALL_LIMIT   = 5000;
    localparam int unsigned IDLE_PERCENT  = 34;
    localparam logic [bpc_pkg::CFG_IDXW-1:0] CFG_IDX_UNUSED = 3'd6;
    localparam logic [bpc_pkg::CFG_IDXW-1:0] CFG_IDX_TOP    = 3'd7;

    // Typical factory calibration, used as a base for realistic phases.
    localparam logic [31:0] TYP_AC1_AC2 = {16'sd408, -16'sd72};
    localparam logic [31:0] TYP_AC3_AC4 = {-16'sd14383, 16'd32741};
    localparam logic [31:0] TYP_AC5_AC6 = {16'd32757, 16'd23153};
    localparam logic [31:0] TYP_B1_B2   = {16'sd6190, 16'sd4};
    localparam logic [31:0] TYP_MC_MD   = {-16'sd8711, 16'sd2868};

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [bpc_pkg::CFG_IDXW-1:0] i_cfg_idx;
    logic [bpc_pkg::CFG_W-1:0]    i_cfg_data;

    bpc_in_if  in_ch();
    bpc_out_if out_ch();

    barometric_pressure_compensation DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the calibration registers as the block should hold them.
    logic [31:0]          cal_shadow [bpc_pkg::NUM_CFG];
    bpc_pkg::t_out_item   pending_results [$];
    int unsigned error_count;
    int unsigned quiet_cycles;
    bit          send_idling;
    bit          recv_idling;
    int unsigned recv_hold;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Integer compensation of one reading pair. Every signed intermediate is a
    // 32-bit int, so sums and products wrap the way the hardware does; >>> is floor.
    function automatic bpc_pkg::t_out_item compensate(input bpc_pkg::t_in_item rd);
        int                 ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut;
        int unsigned        ac4, up, b4, b7, q;
        int                 oss, x1, x2, x3, den, b5, b6, sq, b3, t, p;
        bpc_pkg::t_out_item res;
        ac1 = int'($signed(cal_shadow[bpc_pkg::CFG_AC1_AC2][31:16]));
        ac2 = int'($signed(cal_shadow[bpc_pkg::CFG_AC1_AC2][15:0]));
        ac3 = int'($signed(cal_shadow[bpc_pkg::CFG_AC3_AC4][31:16]));
        ac4 = {16'd0, cal_shadow[bpc_pkg::CFG_AC3_AC4][15:0]};
        ac5 = int'({16'd0, cal_shadow[bpc_pkg::CFG_AC5_AC6][31:16]});
        ac6 = int'({16'd0, cal_shadow[bpc_pkg::CFG_AC5_AC6][15:0]});
        b1  = int'($signed(cal_shadow[bpc_pkg::CFG_B1_B2][31:16]));
        b2  = int'($signed(cal_shadow[bpc_pkg::CFG_B1_B2][15:0]));
        mc  = int'($signed(cal_shadow[bpc_pkg::CFG_MC_MD][31:16]));
        md  = int'($signed(cal_shadow[bpc_pkg::CFG_MC_MD][15:0]));
        oss = int'(cal_shadow[bpc_pkg::CFG_OSS][1:0]);
        ut  = int'({16'd0, rd.raw_temperature});
        up  = {13'd0, rd.raw_pressure};
        res = '0;

        x1  = ((ut - ac6) * ac5) >>> 15;
        den = x1 + md;
        if (den == 0) begin
            res.divide_error = 1'b1;
            return res;
        end
        x2 = (mc * 2048) / den;
        b5 = x1 + x2;
        t  = (b5 + 8) >>> 4;

        b6 = b5 - bpc_pkg::B6_OFFSET;
        sq = (b6 * b6) >>> 12;
        x1 = (b2 * sq) >>> 11;
        x2 = (ac2 * b6) >>> 11;
        x3 = x1 + x2;
        b3 = ((((ac1 * 4) + x3) * (1 << oss)) + 2) / 4;

        x1 = (ac3 * b6) >>> 13;
        x2 = (b1 * sq) >>> 16;
        x3 = (x1 + x2 + 2) >>> 2;
        b4 = (ac4 * unsigned'(x3 + bpc_pkg::B4_BIAS)) >> 15;
        if (b4 == 0) begin
            res.divide_error = 1'b1;
            return res;
        end
        b7 = (up - unsigned'(b3)) * (bpc_pkg::B7_SCALE >> oss);
        // Split keeps 2*B7 from overflowing before the divide.
        if (b7 < bpc_pkg::B7_SPLIT) q = (b7 * 2) / b4;
        else                        q = (b7 / b4) * 2;
        p  = int'(q);

        x1 = p >>> 8;
        x1 = x1 * x1;
        x1 = (x1 * bpc_pkg::P_QUAD_K) >>> 16;
        x2 = (bpc_pkg::P_LIN_K * p) >>> 16;
        p  = p + ((x1 + x2 + bpc_pkg::P_OFFSET) >>> 4);

        if (t > 32767)  t = 32767;
        if (t < -32768) t = -32768;
        if (p < 0)      p = 0;
        if (p > 262143) p = 262143;
        res.temperature_tenths = t[15:0];
        res.pressure_pa        = p[17:0];
        return res;
    endfunction

    // Check each result against the oldest pending expectation.
    always @(posedge i_clk) begin
        bpc_pkg::t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result %h", $time, out_ch.data);
            end else begin
                want = pending_results.pop_front();
                if (out_ch.data.temperature_tenths !== want.temperature_tenths) begin
                    error_count++;
                    $display("%0t: temperature_tenths expected %0d actual %0d", $time,
                             want.temperature_tenths, out_ch.data.temperature_tenths);
                end
                if (out_ch.data.pressure_pa !== want.pressure_pa) begin
                    error_count++;
                    $display("%0t: pressure_pa expected %0d actual %0d", $time,
                             want.pressure_pa, out_ch.data.pressure_pa);
                end
                if (out_ch.data.divide_error !== want.divide_error) begin
                    error_count++;
                    $display("%0t: divide_error expected %0b actual %0b", $time,
                             want.divide_error, out_ch.data.divide_error);
                end
            end
        end
    end

    // Receiver: hold off for a forced stretch, otherwise stall at random when idling.
    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            out_ch.ready <= 1'b0;
            recv_hold--;
        end else begin
            out_ch.ready <= !recv_idling || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog: end the run if neither side moves an item for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one reading pair, with a random gap first when idling; record its result.
    task automatic send_reading(input logic [15:0] ut, input logic [18:0] up);
        int unsigned       gap;
        bpc_pkg::t_in_item rd;
        gap = 0;
        if (send_idling)
            while ($urandom_range(99) < IDLE_PERCENT) gap++;
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        rd.raw_temperature = ut;
        rd.raw_pressure    = up;
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= rd;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(compensate(rd));
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    // Wait until every result is back and the pipeline has emptied.
    task automatic drain();
        stop_sending();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bpc_pkg::CFG_IDXW-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        // Drop writes beyond the register list and bits above the oversampling width.
        if (idx == bpc_pkg::CFG_OSS)      cal_shadow[idx] = {30'd0, val[1:0]};
        else if (idx < bpc_pkg::NUM_CFG)  cal_shadow[idx] = val;
    endtask

    task automatic load_cal(input logic [31:0] r0, r1, r2, r3, r4, input logic [31:0] oss);
        write_reg(bpc_pkg::CFG_AC1_AC2, r0);
        write_reg(bpc_pkg::CFG_AC3_AC4, r1);
        write_reg(bpc_pkg::CFG_AC5_AC6, r2);
        write_reg(bpc_pkg::CFG_B1_B2,   r3);
        write_reg(bpc_pkg::CFG_MC_MD,   r4);
        write_reg(bpc_pkg::CFG_OSS,     oss);
    endtask

    // Realistic pair around the typical operating point, or fully random.
    task automatic send_random_reading(input bit realistic);
        if (realistic)
            send_reading(16'($urandom_range(33000, 22000)), 19'($urandom_range(200000, 15000)));
        else
            send_reading(16'($urandom), 19'($urandom));
    endtask

    // All-zero calibration after reset: the temperature divisor is zero.
    task automatic test_reset_calibration();
        send_reading(16'd27898, 19'd23843);
        send_reading(16'hFFFF, 19'h7FFFF);
        drain();
    endtask

    // Typical calibration across every oversampling setting and field extremes.
    task automatic test_typical_points();
        int m;
        for (m = 0; m < 4; m++) begin
            load_cal(TYP_AC1_AC2, TYP_AC3_AC4, TYP_AC5_AC6, TYP_B1_B2, TYP_MC_MD, m);
            send_reading(16'd27898, 19'(23843 << m));
            send_reading(16'd0, 19'd0);
            send_reading(16'hFFFF, 19'h7FFFF);
            send_reading(16'd0, 19'h7FFFF);
            drain();
        end
    endtask

    // Zero divisors: temperature path (X1 + md) and pressure path (B4).
    task automatic test_zero_divisors();
        load_cal(TYP_AC1_AC2, TYP_AC3_AC4, 32'h0000_1234, TYP_B1_B2, 32'h1234_0000, 32'd0);
        send_reading(16'd27898, 19'd23843);
        drain();
        load_cal(TYP_AC1_AC2, 32'hC7D1_0000, TYP_AC5_AC6, TYP_B1_B2, TYP_MC_MD, 32'd1);
        send_reading(16'd27898, 19'd47686);
        drain();
    endtask

    // Extreme calibration words, ignored register indexes and wide oversampling data.
    task automatic test_extreme_calibration();
        load_cal('1, '1, '1, '1, '1, '1);
        send_reading(16'd0, 19'd0);
        send_reading(16'hFFFF, 19'h7FFFF);
        drain();
        load_cal(32'h7FFF_8000, 32'h8000_FFFF, 32'hFFFF_0000, 32'h8000_7FFF, 32'h7FFF_7FFF,
                 32'hFFFF_FFFE);
        write_reg(CFG_IDX_UNUSED, '1);
        write_reg(CFG_IDX_TOP, '1);
        send_reading(16'h8000, 19'h40000);
        send_reading(16'hFFFF, 19'd0);
        drain();
        // Pressure below the B3 offset pushes B7 over the split point.
        load_cal(32'h7FFF_0000, TYP_AC3_AC4, TYP_AC5_AC6, TYP_B1_B2, TYP_MC_MD, 32'd3);
        send_reading(16'd27898, 19'd1);
        drain();
    endtask

    // Random phases, each with a fresh calibration; one phase without any idling.
    task automatic test_random_readings();
        int phase, n;
        bit realistic_cal;
        for (phase = 0; phase < 6; phase++) begin
            realistic_cal = (phase % 3) != 2;
            if (realistic_cal)
                load_cal(TYP_AC1_AC2 ^ 32'($urandom_range(255)), TYP_AC3_AC4 ^ 32'($urandom_range(255)),
                         TYP_AC5_AC6 ^ 32'($urandom_range(255)), TYP_B1_B2 ^ 32'($urandom_range(255)),
                         TYP_MC_MD ^ 32'($urandom_range(255)), $urandom);
            else
                load_cal($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            send_idling = (phase != 3);
            recv_idling = (phase != 3);
            for (n = 0; n < 110; n++)
                send_random_reading(realistic_cal && ($urandom_range(99) < 70));
            drain();
        end
        send_idling = 1'b1;
        recv_idling = 1'b1;
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall the input.
    task automatic test_output_backpressure();
        int n;
        load_cal(TYP_AC1_AC2, TYP_AC3_AC4, TYP_AC5_AC6, TYP_B1_B2, TYP_MC_MD, 32'd2);
        @(posedge i_clk);
        recv_hold   = 400;
        send_idling = 1'b0;
        for (n = 0; n < 180; n++)
            send_random_reading(1'b1);
        send_idling = 1'b1;
        drain();
    endtask

    initial begin
        int m;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        error_count  = 0;
        quiet_cycles = 0;
        recv_hold    = 0;
        send_idling  = 1'b1;
        recv_idling  = 1'b1;
        for (m = 0; m < bpc_pkg::NUM_CFG; m++) cal_shadow[m] = '0;
        i_rst_n = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_calibration();
        test_typical_points();
        test_zero_divisors();
        test_extreme_calibration();
        test_random_readings();
        test_output_backpressure();

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
